// File: sv/mtd_pkg.sv
package mtd_pkg;

  localparam int MAX_SYMBOLS_DEF = 8;
  localparam int MAX_LETTERS_DEF = 32;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SYM_CNT_W = 5;
  localparam int PAT_W = 6;
  localparam int PAT_MAX = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP = 2'd2;

  localparam logic [CFG_W-1:0] DASH_MIN_RST = 16'd250;
  localparam logic [CFG_W-1:0] LETTER_GAP_RST = 16'd250;
  localparam logic [CFG_W-1:0] WORD_GAP_RST = 16'd650;

  localparam logic [6:0] CODE_UNKNOWN = 7'h3F;

  typedef enum logic [1:0] {
    REQ_TONE    = 2'd0,
    REQ_FLUSH   = 2'd1,
    REQ_CLEAR   = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef struct packed {
    logic                 letter_valid;
    logic [SYM_CNT_W-1:0] sym_count;
    logic [PAT_W-1:0]     sym_bits;
    logic                 letter_stored;
    logic [4:0]           letter_position;
    logic                 word_complete;
    logic [5:0]           word_length;
    logic                 in_tone;
  } mtd_entry_t;

  // Symbol i of the pattern sits in bit i, a dash is a one.
  function automatic logic [6:0] pattern_to_ascii(logic [SYM_CNT_W-1:0] count,
                                                  logic [PAT_W-1:0] bits);
    logic [6:0] code;
    code = CODE_UNKNOWN;
    if (count <= SYM_CNT_W'(PAT_MAX)) begin
      unique case ({count[2:0], bits})
        {3'd2, 6'b000010}: code = 7'("A");
        {3'd4, 6'b000001}: code = 7'("B");
        {3'd4, 6'b000101}: code = 7'("C");
        {3'd3, 6'b000001}: code = 7'("D");
        {3'd1, 6'b000000}: code = 7'("E");
        {3'd4, 6'b000100}: code = 7'("F");
        {3'd3, 6'b000011}: code = 7'("G");
        {3'd4, 6'b000000}: code = 7'("H");
        {3'd2, 6'b000000}: code = 7'("I");
        {3'd4, 6'b001110}: code = 7'("J");
        {3'd3, 6'b000101}: code = 7'("K");
        {3'd4, 6'b000010}: code = 7'("L");
        {3'd2, 6'b000011}: code = 7'("M");
        {3'd2, 6'b000001}: code = 7'("N");
        {3'd3, 6'b000111}: code = 7'("O");
        {3'd4, 6'b000110}: code = 7'("P");
        {3'd4, 6'b001011}: code = 7'("Q");
        {3'd3, 6'b000010}: code = 7'("R");
        {3'd3, 6'b000000}: code = 7'("S");
        {3'd1, 6'b000001}: code = 7'("T");
        {3'd3, 6'b000100}: code = 7'("U");
        {3'd4, 6'b001000}: code = 7'("V");
        {3'd3, 6'b000110}: code = 7'("W");
        {3'd4, 6'b001001}: code = 7'("X");
        {3'd4, 6'b001101}: code = 7'("Y");
        {3'd4, 6'b000011}: code = 7'("Z");
        {3'd5, 6'b011111}: code = 7'("0");
        {3'd5, 6'b011110}: code = 7'("1");
        {3'd5, 6'b011100}: code = 7'("2");
        {3'd5, 6'b011000}: code = 7'("3");
        {3'd5, 6'b010000}: code = 7'("4");
        {3'd5, 6'b000000}: code = 7'("5");
        {3'd5, 6'b000001}: code = 7'("6");
        {3'd5, 6'b000011}: code = 7'("7");
        {3'd5, 6'b000111}: code = 7'("8");
        {3'd5, 6'b001111}: code = 7'("9");
        {3'd6, 6'b101010}: code = 7'(".");
        {3'd6, 6'b110011}: code = 7'(",");
        {3'd6, 6'b001100}: code = 7'("?");
        {3'd5, 6'b001001}: code = 7'("/");
        {3'd6, 6'b100001}: code = 7'("-");
        {3'd6, 6'b101101}: code = 7'("(");
        default:           code = CODE_UNKNOWN;
      endcase
    end
    return code;
  endfunction

endpackage

// File: sv/morse_tone_decoder.sv
// Channel   Handshake             Payload
// input     in_valid / in_stall   req_type, tone_on, tick_time
// output    out_valid / out_stall letter_valid, letter_code, letter_stored,
//                                 letter_position, word_complete, word_length, in_tone
// config    cfg_we                cfg_index, cfg_data
//
// One item is taken in every cycle unless the queue is full; the front updates the
// receiver state in the cycle of the transfer, so the state loop sets that rate.
// A result is written into the queue at its transfer and then into the output register.
// Reset clears control state, loads the register defaults at once; no clearing pass follows.
// The input stalls only when the two-entry queue is full, which happens only after the
// output has stalled.
module morse_tone_decoder
  import mtd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic                 tone_on,
  input  logic [31:0]          tick_time,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 letter_valid,
  output logic [6:0]           letter_code,
  output logic                 letter_stored,
  output logic [4:0]           letter_position,
  output logic                 word_complete,
  output logic [5:0]           word_length,
  output logic                 in_tone
);

  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;
  mtd_entry_t entry;
  mtd_entry_t head;

  mtd_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .MAX_LETTERS(MAX_LETTERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .tone_on   (tone_on),
    .tick_time (tick_time),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  mtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (head)
  );

  mtd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .letter_valid    (letter_valid),
    .letter_code     (letter_code),
    .letter_stored   (letter_stored),
    .letter_position (letter_position),
    .word_complete   (word_complete),
    .word_length     (word_length),
    .in_tone         (in_tone)
  );

endmodule

// File: sv/mtd_front.sv
module mtd_front
  import mtd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int MAX_LETTERS = MAX_LETTERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic                 tone_on,
  input  logic [31:0]          tick_time,
  input  logic                 q_full,
  output logic                 push,
  output mtd_entry_t           entry
);

  localparam int SCW = $clog2(MAX_SYMBOLS + 1);
  localparam int SIW = $clog2(MAX_SYMBOLS);
  localparam int LCW = $clog2(MAX_LETTERS + 1);

  logic [CFG_W-1:0] dash_min;
  logic [CFG_W-1:0] letter_gap;
  logic [CFG_W-1:0] word_gap;

  logic                   tone_phase, tone_phase_next;
  logic [31:0]            phase_start, phase_start_next;
  logic [SCW-1:0]         symbol_count, symbol_count_next;
  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [LCW-1:0]         letter_count, letter_count_next;
  logic                   word_done, word_done_next;

  logic        do_commit;
  logic        do_word;
  logic [31:0] dt;
  req_t        req;

  assign in_stall = q_full;
  assign push = in_valid && !q_full;
  assign req = req_t'(req_type);
  assign dt = tick_time - phase_start;

  always_comb begin
    tone_phase_next = tone_phase;
    phase_start_next = phase_start;
    symbol_count_next = symbol_count;
    symbol_bits_next = symbol_bits;
    letter_count_next = letter_count;
    word_done_next = word_done;
    do_commit = 1'b0;
    do_word = 1'b0;
    entry = '0;

    unique case (req)
      REQ_TONE: begin
        if (!tone_phase && tone_on) begin
          if (dt >= {16'd0, word_gap}) begin
            do_commit = 1'b1;
            do_word = 1'b1;
          end else if (dt >= {16'd0, letter_gap}) begin
            do_commit = 1'b1;
          end
          tone_phase_next = 1'b1;
          phase_start_next = tick_time;
        end else if (tone_phase && !tone_on) begin
          if (symbol_count < SCW'(MAX_SYMBOLS)) begin
            if (dt >= {16'd0, dash_min}) begin
              symbol_bits_next[symbol_count[SIW-1:0]] = 1'b1;
            end
            symbol_count_next = symbol_count + 1'b1;
          end
          tone_phase_next = 1'b0;
          phase_start_next = tick_time;
        end
      end
      REQ_FLUSH: begin
        do_commit = 1'b1;
        do_word = 1'b1;
      end
      REQ_CLEAR: begin
        word_done_next = 1'b0;
        letter_count_next = '0;
      end
      REQ_RESTART: begin
        tone_phase_next = 1'b0;
        phase_start_next = tick_time;
        symbol_count_next = '0;
        symbol_bits_next = '0;
        letter_count_next = '0;
        word_done_next = 1'b0;
      end
      default: begin
      end
    endcase

    if (do_commit && symbol_count != '0) begin
      entry.letter_valid = 1'b1;
      entry.sym_count = SYM_CNT_W'(symbol_count);
      entry.sym_bits = PAT_W'(symbol_bits);
      if (letter_count < LCW'(MAX_LETTERS)) begin
        entry.letter_stored = 1'b1;
        entry.letter_position = 5'(letter_count);
        letter_count_next = letter_count + 1'b1;
      end
      symbol_count_next = '0;
      symbol_bits_next = '0;
    end
    if (do_word && letter_count_next != '0) begin
      word_done_next = 1'b1;
    end

    entry.word_complete = word_done_next;
    entry.word_length = 6'(letter_count_next);
    entry.in_tone = tone_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_min <= DASH_MIN_RST;
      letter_gap <= LETTER_GAP_RST;
      word_gap <= WORD_GAP_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_DASH_MIN) dash_min <= cfg_data;
      if (cfg_index == REG_LETTER_GAP) letter_gap <= cfg_data;
      if (cfg_index == REG_WORD_GAP) word_gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_phase <= 1'b0;
      phase_start <= '0;
      symbol_count <= '0;
      symbol_bits <= '0;
      letter_count <= '0;
      word_done <= 1'b0;
    end else if (push) begin
      tone_phase <= tone_phase_next;
      phase_start <= phase_start_next;
      symbol_count <= symbol_count_next;
      symbol_bits <= symbol_bits_next;
      letter_count <= letter_count_next;
      word_done <= word_done_next;
    end
  end

  a_sym_bound: assert property (@(posedge clk) disable iff (rst)
    symbol_count <= SCW'(MAX_SYMBOLS))
    else $error("symbol count beyond its limit");

  a_letter_bound: assert property (@(posedge clk) disable iff (rst)
    letter_count <= LCW'(MAX_LETTERS))
    else $error("letter count beyond word capacity");

  a_done_needs_letters: assert property (@(posedge clk) disable iff (rst)
    word_done |-> letter_count != '0)
    else $error("word marked ready with no letters");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (push && req == REQ_RESTART) |=> (symbol_count == '0 && !tone_phase && !word_done))
    else $error("restart left state behind");

endmodule

// File: sv/mtd_queue.sv
module mtd_queue
  import mtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  mtd_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output mtd_entry_t head
);

  mtd_entry_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/mtd_back.sv
module mtd_back
  import mtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  mtd_entry_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       letter_valid,
  output logic [6:0] letter_code,
  output logic       letter_stored,
  output logic [4:0] letter_position,
  output logic       word_complete,
  output logic [5:0] word_length,
  output logic       in_tone
);

  assign pop = q_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      letter_valid <= head.letter_valid;
      letter_code <= head.letter_valid ? pattern_to_ascii(head.sym_count, head.sym_bits)
                                       : 7'd0;
      letter_stored <= head.letter_stored;
      letter_position <= head.letter_position;
      word_complete <= head.word_complete;
      word_length <= head.word_length;
      in_tone <= head.in_tone;
    end
  end

endmodule
